// File: hw/rtl/exptok_pkg.sv
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Token codes, the token record passed from the scanner to the result unit,
// and the small decimal power table used for the fraction conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package exptok_pkg;

  // Token kinds.
  localparam logic [3:0] TK_END    = 4'd0;
  localparam logic [3:0] TK_VAR    = 4'd1;
  localparam logic [3:0] TK_FUNC   = 4'd2;
  localparam logic [3:0] TK_DERIV  = 4'd3;
  localparam logic [3:0] TK_NUM    = 4'd4;
  localparam logic [3:0] TK_OP     = 4'd5;
  localparam logic [3:0] TK_LPAREN = 4'd6;
  localparam logic [3:0] TK_RPAREN = 4'd7;
  localparam logic [3:0] TK_ERR    = 4'd8;

  // Function identifiers.
  localparam logic [2:0] FN_SIN = 3'd0;
  localparam logic [2:0] FN_COS = 3'd1;
  localparam logic [2:0] FN_EXP = 3'd2;
  localparam logic [2:0] FN_LOG = 3'd3;

  // Operator identifiers and precedences.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic [3:0] PREC_NONE = 4'd0;
  localparam logic [3:0] PREC_LOW  = 4'd5;
  localparam logic [3:0] PREC_HIGH = 4'd10;

  // Derivative identifier of a plain f.
  localparam logic [2:0] DV_F = 3'd0;

  // Width of the fraction digit count.
  localparam int unsigned FC_W = 3;

  // Entries of the token queue.
  localparam int unsigned Q_DEPTH = 4;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] ident;
    logic [4:0] order;
    logic [3:0] prec;
    logic       last;
  } tok_t;

  localparam int unsigned TOK_W = $bits(tok_t);

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [2:0] ident,
                                  input logic [4:0] order, input logic [3:0] prec);
    tok_t t;
    t.kind  = kind;
    t.ident = ident;
    t.order = order;
    t.prec  = prec;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic logic [31:0] pow10(input logic [FC_W-1:0] n);
    logic [31:0] p;
    unique case (n)
      3'd0:    p = 32'd1;
      3'd1:    p = 32'd10;
      3'd2:    p = 32'd100;
      3'd3:    p = 32'd1000;
      3'd4:    p = 32'd10000;
      3'd5:    p = 32'd100000;
      3'd6:    p = 32'd1000000;
      default: p = 32'd10000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/exptok_fifo.sv
// ----------------------------------------------------------------------------
// Token queue
// Small first-in first-out buffer between the scanner and the result unit.
// ----------------------------------------------------------------------------
`default_nettype none

module exptok_fifo #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/exptok_front.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Accepts characters, tracks the word or number being built, classifies
// finished tokens and pushes them into the token queue.
// ----------------------------------------------------------------------------
`default_nettype none

module exptok_front #(
  parameter int unsigned MAX_TOKEN_LEN       = 31,
  parameter int unsigned MAX_FRACTION_DIGITS = 6,
  parameter int unsigned INT_BITS            = 16,
  parameter int unsigned FRAC_W              = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      character_i,
  input  logic                            end_marker_i,
  output logic                            push_o,
  output exptok_pkg::tok_t                push_tok_o,
  output logic [INT_BITS:0]               push_ip_o,
  output logic [FRAC_W-1:0]               push_fd_o,
  output logic [exptok_pkg::FC_W-1:0]     push_fc_o,
  input  logic                            full_i
);

  import exptok_pkg::*;

  localparam int unsigned WLW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned IPW = INT_BITS + 1;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_WORD = 2'd1;
  localparam logic [1:0] M_NUM  = 2'd2;
  localparam logic [1:0] M_ERR  = 2'd3;

  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_VAR    = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_F      = 2'd3;

  localparam logic [23:0] W_SIN = "sin";
  localparam logic [23:0] W_COS = "cos";
  localparam logic [23:0] W_EXP = "exp";
  localparam logic [23:0] W_LOG = "log";

  // Bit 2 flags a variable letter, bits 1:0 give its code.
  function automatic logic [2:0] var_code(input logic [7:0] ch);
    logic [2:0] r;
    if (ch == "x") begin
      r = 3'b100;
    end else if (ch == "y") begin
      r = 3'b101;
    end else if (ch == "z") begin
      r = 3'b110;
    end else if (ch == "t") begin
      r = 3'b111;
    end else begin
      r = 3'b000;
    end
    return r;
  endfunction

  logic [1:0]        mode_q, mode_d;
  logic [WLW-1:0]    wl_q, wl_d;
  logic [23:0]       ll_q, ll_d;
  logic [4:0]        pc_q, pc_d;
  logic [1:0]        ph_q, ph_d;
  logic [IPW-1:0]    ip_q, ip_d;
  logic [FRAC_W-1:0] fd_q, fd_d;
  logic [FC_W-1:0]   fc_q, fc_d;
  logic [1:0]        dot_q, dot_d;
  logic              pend_q, pend_d;
  tok_t              pend_tok_q, pend_tok_d;

  logic [7:0]  c;
  logic        is_letter, is_digit, is_space, is_dot, acc;
  logic [2:0]  vc_c, vc_first, vc_second;
  logic [7:0]  first, second;
  logic [5:0]  order_raw;
  logic [4:0]  order_sat;
  tok_t        wtok, ntok, htok, t0, t1;
  logic        wbad, h_err, n0, n1, clr, handle;
  logic [IPW+3:0]    ip_ext;
  logic [FRAC_W+3:0] fd_ext;

  assign c         = character_i;
  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit  = (c >= "0" && c <= "9");
  assign is_space  = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign is_dot    = (c == ".");
  assign vc_c      = var_code(c);
  assign first     = ll_q[23:16];
  assign second    = ll_q[15:8];
  assign vc_first  = var_code(first);
  assign vc_second = var_code(second);

  assign in_ready_o = !pend_q && !full_i;
  assign acc        = in_valid_i && in_ready_o;

  // Classification of the word held in the state registers.
  assign order_raw = {1'b0, pc_q} + ((ph_q == PH_F) ? 6'd1 : 6'd0);
  assign order_sat = order_raw[5] ? 5'd31 : order_raw[4:0];

  always_comb begin
    wbad = 1'b0;
    if (vc_first[2]) begin
      wtok = mk_tok(TK_VAR, {1'b0, vc_first[1:0]}, 5'd0, PREC_NONE);
    end else if (ll_q == W_SIN) begin
      wtok = mk_tok(TK_FUNC, FN_SIN, 5'd0, PREC_NONE);
    end else if (ll_q == W_COS) begin
      wtok = mk_tok(TK_FUNC, FN_COS, 5'd0, PREC_NONE);
    end else if (ll_q == W_EXP) begin
      wtok = mk_tok(TK_FUNC, FN_EXP, 5'd0, PREC_NONE);
    end else if (ll_q == W_LOG) begin
      wtok = mk_tok(TK_FUNC, FN_LOG, 5'd0, PREC_NONE);
    end else if (order_sat != 5'd0) begin
      wtok = mk_tok(TK_DERIV,
                    (first == "f") ? DV_F : 3'd1 + {1'b0, vc_second[1:0]},
                    order_sat, PREC_NONE);
    end else begin
      wtok = mk_tok(TK_ERR, 3'd0, 5'd0, PREC_NONE);
      wbad = 1'b1;
    end
  end

  assign ntok = mk_tok(TK_NUM, 3'd0, 5'd0, PREC_NONE);

  // Token for a character seen outside a word or number.
  always_comb begin
    h_err = 1'b0;
    if (c == "+") begin
      htok = mk_tok(TK_OP, OP_ADD, 5'd0, PREC_LOW);
    end else if (c == "-") begin
      htok = mk_tok(TK_OP, OP_SUB, 5'd0, PREC_LOW);
    end else if (c == "*") begin
      htok = mk_tok(TK_OP, OP_MUL, 5'd0, PREC_HIGH);
    end else if (c == "/") begin
      htok = mk_tok(TK_OP, OP_DIV, 5'd0, PREC_HIGH);
    end else if (c == "(") begin
      htok = mk_tok(TK_LPAREN, 3'd0, 5'd0, PREC_NONE);
    end else if (c == ")") begin
      htok = mk_tok(TK_RPAREN, 3'd0, 5'd0, PREC_NONE);
    end else begin
      htok = mk_tok(TK_ERR, 3'd0, 5'd0, PREC_NONE);
      h_err = 1'b1;
    end
  end

  assign ip_ext = ({4'b0, ip_q} << 3) + ({4'b0, ip_q} << 1) + (IPW+4)'(c[3:0]);
  assign fd_ext = ({4'b0, fd_q} << 3) + ({4'b0, fd_q} << 1) + (FRAC_W+4)'(c[3:0]);

  always_comb begin
    mode_d = mode_q;
    wl_d   = wl_q;
    ll_d   = ll_q;
    pc_d   = pc_q;
    ph_d   = ph_q;
    ip_d   = ip_q;
    fd_d   = fd_q;
    fc_d   = fc_q;
    dot_d  = dot_q;
    t0     = mk_tok(TK_END, 3'd0, 5'd0, PREC_NONE);
    t1     = mk_tok(TK_END, 3'd0, 5'd0, PREC_NONE);
    n0     = 1'b0;
    n1     = 1'b0;
    clr    = 1'b0;
    handle = 1'b0;

    if (acc) begin
      if (end_marker_i) begin
        if (mode_q == M_WORD) begin
          t0 = wtok;
          n0 = 1'b1;
          n1 = 1'b1;
        end else if (mode_q == M_NUM) begin
          t0 = ntok;
          n0 = 1'b1;
          n1 = 1'b1;
        end else begin
          n0 = 1'b1;
        end
        mode_d = M_IDLE;
        clr    = 1'b1;
      end else if (mode_q == M_WORD) begin
        if (is_letter) begin
          if (wl_q < WLW'(MAX_TOKEN_LEN)) begin
            if (wl_q == WLW'(0)) begin
              ll_d[23:16] = c;
            end else if (wl_q == WLW'(1)) begin
              ll_d[15:8] = c;
            end else if (wl_q == WLW'(2)) begin
              ll_d[7:0] = c;
            end
            if (ph_q == PH_EXPECT) begin
              ph_d = (c == "f") ? PH_F : ((c == "d") ? PH_VAR : PH_DONE);
            end else if (ph_q == PH_VAR) begin
              if (vc_c[2]) begin
                if (pc_q != 5'd31) begin
                  pc_d = pc_q + 5'd1;
                end
                ph_d = PH_EXPECT;
              end else begin
                ph_d = PH_DONE;
              end
            end
            wl_d = wl_q + WLW'(1);
          end
        end else begin
          t0  = wtok;
          n0  = 1'b1;
          clr = 1'b1;
          if (wbad) begin
            mode_d = M_ERR;
          end else begin
            mode_d = M_IDLE;
            handle = 1'b1;
          end
        end
      end else if (mode_q == M_NUM) begin
        if (is_dot) begin
          if (dot_q != 2'd2) begin
            dot_d = dot_q + 2'd1;
          end
        end else if (is_digit) begin
          if (dot_q == 2'd0) begin
            ip_d = (ip_ext > (IPW+4)'(1) << INT_BITS) ? IPW'(1) << INT_BITS
                                                      : ip_ext[IPW-1:0];
          end else if (dot_q == 2'd1 && fc_q < FC_W'(MAX_FRACTION_DIGITS)) begin
            fd_d = fd_ext[FRAC_W-1:0];
            fc_d = fc_q + FC_W'(1);
          end
        end else begin
          t0     = ntok;
          n0     = 1'b1;
          clr    = 1'b1;
          mode_d = M_IDLE;
          handle = 1'b1;
        end
      end else if (mode_q == M_IDLE) begin
        handle = 1'b1;
      end
    end

    if (clr) begin
      wl_d  = '0;
      ll_d  = '0;
      pc_d  = '0;
      ph_d  = PH_EXPECT;
      ip_d  = '0;
      fd_d  = '0;
      fc_d  = '0;
      dot_d = '0;
    end

    // The state is clear here, so a new word or number starts from scratch.
    if (handle) begin
      if (is_space) begin
        mode_d = mode_d;
      end else if (is_letter) begin
        mode_d = M_WORD;
        wl_d   = WLW'(1);
        ll_d   = {c, 16'h0000};
        ph_d   = (c == "f") ? PH_F : ((c == "d") ? PH_VAR : PH_DONE);
      end else if (is_digit) begin
        mode_d = M_NUM;
        ip_d   = IPW'(c[3:0]);
      end else begin
        if (n0) begin
          t1 = htok;
          n1 = 1'b1;
        end else begin
          t0 = htok;
          n0 = 1'b1;
        end
        if (h_err) begin
          mode_d = M_ERR;
        end
      end
    end

    if (n1) begin
      t1.last = 1'b1;
    end else if (n0) begin
      t0.last = 1'b1;
    end
  end

  // A second token of the same character waits in the pending slot until the queue has room.
  assign push_o     = (acc && n0) || (pend_q && !full_i);
  assign push_tok_o = pend_q ? pend_tok_q : t0;
  assign push_ip_o  = ip_q;
  assign push_fd_o  = fd_q;
  assign push_fc_o  = fc_q;

  always_comb begin
    pend_d     = pend_q;
    pend_tok_d = pend_tok_q;
    if (pend_q && !full_i) begin
      pend_d = 1'b0;
    end
    if (acc && n1) begin
      pend_d     = 1'b1;
      pend_tok_d = t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      wl_q   <= '0;
      ll_q   <= '0;
      pc_q   <= '0;
      ph_q   <= PH_EXPECT;
      ip_q   <= '0;
      fd_q   <= '0;
      fc_q   <= '0;
      dot_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      wl_q   <= wl_d;
      ll_q   <= ll_d;
      pc_q   <= pc_d;
      ph_q   <= ph_d;
      ip_q   <= ip_d;
      fd_q   <= fd_d;
      fc_q   <= fc_d;
      dot_q  <= dot_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tok_q <= pend_tok_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/exptok_back.sv
// ----------------------------------------------------------------------------
// Tokenizer result unit
// Pops tokens from the queue, converts number tokens to unsigned fixed point
// with a restoring divider, and holds each result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module exptok_back #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned FRAC_W    = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  exptok_pkg::tok_t            tok_i,
  input  logic [INT_BITS:0]           ip_i,
  input  logic [FRAC_W-1:0]           fd_i,
  input  logic [exptok_pkg::FC_W-1:0] fc_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  token_kind_o,
  output logic [2:0]                  ident_o,
  output logic [4:0]                  deriv_order_o,
  output logic [3:0]                  precedence_o,
  output logic [31:0]                 number_value_o,
  output logic                        last_of_run_o
);

  import exptok_pkg::*;

  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned NW  = FRAC_W + QW;
  localparam int unsigned CW  = $clog2(QW + 1);
  localparam int unsigned VW  = INT_BITS + FRAC_BITS;
  localparam int unsigned IPW = INT_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ov_q, ov_d;
  logic [FRAC_W-1:0] rem_q, rem_d, p10_q, p10_d;
  logic [QW-1:0]     sh_q, sh_d;
  logic [IPW-1:0]    ip_q, ip_d;
  logic              last_q, last_d;
  tok_t              otok_q, otok_d;
  logic [31:0]       onum_q, onum_d;

  logic              free, ld_tok, ld_num;
  logic [FRAC_W-1:0] p10_in;
  logic [NW-1:0]     numer;
  logic [FRAC_W:0]   trial;
  logic              ge;
  logic [IPW:0]      ip_rnd;
  logic              sat;
  logic [VW-1:0]     val;
  logic [VW+31:0]    val_ext;

  assign free   = !ov_q || out_ready_i;
  assign p10_in = FRAC_W'(pow10(fc_i));
  // Scaled fraction plus half the divisor, so the quotient rounds to nearest.
  assign numer  = NW'({fd_i, {FRAC_BITS{1'b0}}}) + NW'(p10_in >> 1);

  assign trial  = {rem_q, sh_q[QW-1]};
  assign ge     = (trial >= {1'b0, p10_q});

  // A quotient of exactly one carries into the integer part.
  assign ip_rnd  = {1'b0, ip_q} + (IPW+1)'(sh_q[FRAC_BITS]);
  assign sat     = (ip_rnd >= (IPW+1)'(1) << INT_BITS);
  assign val     = sat ? {VW{1'b1}} : {ip_rnd[INT_BITS-1:0], sh_q[FRAC_BITS-1:0]};
  assign val_ext = {32'h0, val};

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    p10_d  = p10_q;
    ip_d   = ip_q;
    last_d = last_q;
    otok_d = otok_q;
    onum_d = onum_q;
    pop_o  = 1'b0;
    ld_tok = 1'b0;
    ld_num = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (tok_i.kind == TK_NUM) begin
            pop_o  = 1'b1;
            rem_d  = numer[NW-1:QW];
            p10_d  = p10_in;
            ip_d   = ip_i;
            last_d = tok_i.last;
            cnt_d  = CW'(QW);
            if (fc_i == '0) begin
              sh_d = '0;
              st_d = S_FIN;
            end else begin
              sh_d = numer[QW-1:0];
              st_d = S_DIV;
            end
          end else if (free) begin
            pop_o  = 1'b1;
            ld_tok = 1'b1;
            otok_d = tok_i;
            onum_d = '0;
          end
        end
      end
      S_DIV: begin
        rem_d = ge ? FRAC_W'(trial - {1'b0, p10_q}) : trial[FRAC_W-1:0];
        sh_d  = {sh_q[QW-2:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        if (free) begin
          ld_num      = 1'b1;
          otok_d      = mk_tok(TK_NUM, 3'd0, 5'd0, PREC_NONE);
          otok_d.last = last_q;
          onum_d      = val_ext[31:0];
          st_d        = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    if (ld_tok || ld_num) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    p10_q  <= p10_d;
    ip_q   <= ip_d;
    last_q <= last_d;
    otok_q <= otok_d;
    onum_q <= onum_d;
  end

  assign out_valid_o    = ov_q;
  assign token_kind_o   = otok_q.kind;
  assign ident_o        = otok_q.ident;
  assign deriv_order_o  = otok_q.order;
  assign precedence_o   = otok_q.prec;
  assign number_value_o = onum_q;
  assign last_of_run_o  = otok_q.last;

endmodule

`default_nettype wire

// File: hw/rtl/expression_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Expression tokenizer
// Turns a stream of ASCII characters into variable, function, derivative,
// number, operator and parenthesis tokens; numbers come out in unsigned
// fixed point with INT_BITS integer and FRAC_BITS fraction bits.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   character, end_marker
//   output   out        out_valid / out_ready token_kind, ident, deriv_order,
//                                             precedence, number_value,
//                                             last_of_run
//
// The scanner takes one character per cycle while the token queue has room; a
// character that causes two tokens holds off the next one until its second
// token is in the queue. Tokens other than numbers go straight to the output
// register once it is free; a number with fraction digits passes load, FRAC_BITS+1
// divider steps and packing in the result unit, one without them load and packing.
// A four-entry token queue lets the scanner run on while the divider works.
// Reset returns the scanner to idle and empties the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_tokenizer_top #(
  parameter int unsigned MAX_TOKEN_LEN       = 31,
  parameter int unsigned MAX_FRACTION_DIGITS = 6,
  parameter int unsigned INT_BITS            = 16,
  parameter int unsigned FRAC_BITS           = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        end_marker_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [2:0]  ident_o,
  output logic [4:0]  deriv_order_o,
  output logic [3:0]  precedence_o,
  output logic [31:0] number_value_o,
  output logic        last_of_run_o
);

  import exptok_pkg::*;

  localparam int unsigned FracW = $clog2(pow10(FC_W'(MAX_FRACTION_DIGITS)) + 32'd1);
  localparam int unsigned IPW   = INT_BITS + 1;
  localparam int unsigned EW    = TOK_W + IPW + FracW + FC_W;

  logic             push, full, pop, empty;
  tok_t             push_tok;
  logic [IPW-1:0]   push_ip;
  logic [FracW-1:0] push_fd;
  logic [FC_W-1:0]  push_fc;
  logic [EW-1:0]    q_wdata, q_rdata;
  tok_t             q_tok;
  logic [IPW-1:0]   q_ip;
  logic [FracW-1:0] q_fd;
  logic [FC_W-1:0]  q_fc;

  exptok_front #(
    .MAX_TOKEN_LEN       (MAX_TOKEN_LEN),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .INT_BITS            (INT_BITS),
    .FRAC_W              (FracW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .character_i  (character_i),
    .end_marker_i (end_marker_i),
    .push_o       (push),
    .push_tok_o   (push_tok),
    .push_ip_o    (push_ip),
    .push_fd_o    (push_fd),
    .push_fc_o    (push_fc),
    .full_i       (full)
  );

  assign q_wdata = {push_tok, push_ip, push_fd, push_fc};

  exptok_fifo #(
    .WIDTH (EW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  assign {q_tok, q_ip, q_fd, q_fc} = q_rdata;

  exptok_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS),
    .FRAC_W    (FracW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .tok_i          (q_tok),
    .ip_i           (q_ip),
    .fd_i           (q_fd),
    .fc_i           (q_fc),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .ident_o        (ident_o),
    .deriv_order_o  (deriv_order_o),
    .precedence_o   (precedence_o),
    .number_value_o (number_value_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/exptok_chk.sv
// ----------------------------------------------------------------------------
// Expression tokenizer checker
// Watches the top-level ports for output handshake rules and for token
// fields that must be zero or fixed for a given token kind.
// ----------------------------------------------------------------------------
`default_nettype none

module exptok_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_o,
  input logic [2:0]  ident_o,
  input logic [4:0]  deriv_order_o,
  input logic [3:0]  precedence_o,
  input logic [31:0] number_value_o,
  input logic        last_of_run_o
);

  import exptok_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(token_kind_o) && $stable(ident_o) &&
      $stable(deriv_order_o) && $stable(precedence_o) &&
      $stable(number_value_o) && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

  a_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != TK_NUM |-> number_value_o == 32'h0)
    else $error("number value on a token that is not a number");

  a_op_prec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == TK_OP |-> precedence_o == PREC_LOW ||
      precedence_o == PREC_HIGH)
    else $error("operator token without a valid precedence");

  a_deriv_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != TK_DERIV |-> deriv_order_o == 5'd0)
    else $error("derivative order on a token that is not a derivative");

endmodule

bind expression_tokenizer_top exptok_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .ident_o        (ident_o),
  .deriv_order_o  (deriv_order_o),
  .precedence_o   (precedence_o),
  .number_value_o (number_value_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire
